// File: rtl/ber_oid_arc_decoder_assert.svh
// Assertion macros shared by the decoder checker.
`ifndef BER_OID_ARC_DECODER_ASSERT_SVH
`define BER_OID_ARC_DECODER_ASSERT_SVH

// Clocked on clk, quiet while rst is high.
`define BOAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked across reset.
`define BOAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/boad_pkg.sv
// Types, constants and helpers for the BER OID arc decoder.
package boad_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0]  ARC_LIMIT     = 8'd128;
  localparam logic [7:0]  OID_TAG_RESET = 8'd6;
  // accumulator above this would lose bits on the next 7-bit shift
  localparam logic [31:0] SHIFT_LIMIT   = 32'h01FF_FFFF;

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_TAG  = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TRUNC    = 3'd4
  } boad_status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_ARCS = 1'b0,
    REG_OID_TAG  = 1'b1
  } boad_reg_t;

  typedef struct packed {
    logic [7:0] max_arcs;
    logic [7:0] oid_tag;
  } boad_cfg_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [7:0] data_byte;
    logic       is_first;
    logic       is_last;
    logic       is_empty;
  } boad_item_t;

  typedef struct packed {
    logic [31:0]  arc;
    logic         arc_valid;
    boad_status_t status;
    logic         done_res;
    logic [7:0]   arc_count;
  } boad_res_t;

  // byte / 40 as ((byte >> 3) * 13) >> 6, exact for all 8-bit values
  function automatic logic [2:0] div40(input logic [7:0] b);
    logic [8:0] p;
    p = 9'(b[7:3]) * 9'd13;
    return p[8:6];
  endfunction

  function automatic logic [5:0] mod40(input logic [7:0] b);
    logic [2:0] q;
    logic [7:0] qm;
    logic [7:0] r;
    q  = div40(b);
    qm = {q, 5'b0} + {2'b0, q, 3'b0};
    r  = b - qm;
    return r[5:0];
  endfunction

  function automatic boad_res_t err_res(input boad_status_t st);
    boad_res_t r;
    r.arc       = '0;
    r.arc_valid = 1'b0;
    r.status    = st;
    r.done_res  = 1'b1;
    r.arc_count = '0;
    return r;
  endfunction

endpackage

// File: rtl/boad_step.sv
// Per-octet decode: state registers plus the logic that folds one octet in.
module boad_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  boad_pkg::boad_item_t item,
  input  boad_pkg::boad_cfg_t  cfg,
  output boad_pkg::boad_res_t  res0,
  output boad_pkg::boad_res_t  res1,
  output logic [1:0]         n_res
);
  import boad_pkg::*;

  logic [31:0] arc_accum, arc_accum_next;
  logic [7:0]  arcs_emitted, arcs_emitted_next;
  logic        discarding, discarding_next;

  logic [31:0] acc_sh;
  logic [7:0]  emit_inc;
  logic        opens;

  assign opens    = item.is_first | item.is_empty;
  assign acc_sh   = {arc_accum[24:0], item.data_byte[6:0]};
  assign emit_inc = arcs_emitted + 8'd1;

  always_comb begin
    arc_accum_next    = arc_accum;
    arcs_emitted_next = arcs_emitted;
    discarding_next   = discarding;
    res0              = err_res(ST_OK);
    res1              = err_res(ST_OK);
    n_res             = 2'd0;
    if (opens) begin
      // a first item abandons whatever was open
      arc_accum_next    = '0;
      arcs_emitted_next = '0;
      discarding_next   = 1'b0;
      n_res             = 2'd1;
      if (item.tag != cfg.oid_tag) begin
        res0            = err_res(ST_BAD_TAG);
        discarding_next = !(item.is_empty | item.is_last);
      end else if (item.is_empty) begin
        res0 = err_res(ST_BAD_LEN);
      end else if (cfg.max_arcs < 8'd2) begin
        res0            = err_res(ST_OVERFLOW);
        discarding_next = !item.is_last;
      end else begin
        n_res          = 2'd2;
        res0.arc       = {29'b0, div40(item.data_byte)};
        res0.arc_valid = 1'b1;
        res0.done_res  = 1'b0;
        res1.arc       = {26'b0, mod40(item.data_byte)};
        res1.arc_valid = 1'b1;
        res1.done_res  = item.is_last;
        res1.arc_count = item.is_last ? 8'd2 : 8'd0;
        arcs_emitted_next = item.is_last ? 8'd0 : 8'd2;
      end
    end else if (discarding) begin
      if (item.is_last) begin
        discarding_next = 1'b0;
      end
    end else if (arcs_emitted != 8'd0) begin
      if (arc_accum > SHIFT_LIMIT) begin
        n_res             = 2'd1;
        res0              = err_res(ST_OVERFLOW);
        arc_accum_next    = '0;
        arcs_emitted_next = '0;
        discarding_next   = !item.is_last;
      end else if (item.data_byte[7]) begin
        if (item.is_last) begin
          n_res             = 2'd1;
          res0              = err_res(ST_TRUNC);
          arc_accum_next    = '0;
          arcs_emitted_next = '0;
        end else begin
          arc_accum_next = acc_sh;
        end
      end else if (arcs_emitted >= cfg.max_arcs) begin
        n_res             = 2'd1;
        res0              = err_res(ST_OVERFLOW);
        arc_accum_next    = '0;
        arcs_emitted_next = '0;
        discarding_next   = !item.is_last;
      end else begin
        n_res             = 2'd1;
        res0.arc          = acc_sh;
        res0.arc_valid    = 1'b1;
        res0.done_res     = item.is_last;
        res0.arc_count    = item.is_last ? emit_inc : 8'd0;
        arc_accum_next    = '0;
        arcs_emitted_next = item.is_last ? 8'd0 : emit_inc;
      end
    end
    if (!en) begin
      n_res = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_accum    <= '0;
      arcs_emitted <= '0;
      discarding   <= 1'b0;
    end else if (en) begin
      arc_accum    <= arc_accum_next;
      arcs_emitted <= arcs_emitted_next;
      discarding   <= discarding_next;
    end
  end

endmodule

// File: rtl/boad_outq.sv
// Small result queue: takes up to two results a cycle, gives one.
module boad_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         n_push,
  input  boad_pkg::boad_res_t  push0,
  input  boad_pkg::boad_res_t  push1,
  input  logic               pop,
  output boad_pkg::boad_res_t  head,
  output logic               not_empty,
  output logic               room2
);
  import boad_pkg::*;

  boad_res_t             mem [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [OUTQ_PTR_W-1:0] wr_ptr_p1;
  logic [OUTQ_CNT_W-1:0] count, count_next;
  logic                  do_pop;

  assign not_empty = (count != '0);
  assign room2     = (count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign head      = mem[rd_ptr];
  assign do_pop    = pop & not_empty;
  assign wr_ptr_p1 = wr_ptr + 1'b1;
  assign count_next = count + OUTQ_CNT_W'(n_push) - OUTQ_CNT_W'(do_pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(n_push);
      rd_ptr <= rd_ptr + OUTQ_PTR_W'(do_pop);
      count  <= count_next;
    end
  end

endmodule

// File: rtl/ber_oid_arc_decoder.sv
// Top level of the BER OBJECT IDENTIFIER arc decoder.
// Takes one content octet per transaction and emits decoded arcs. An octet is
// registered on input, then decoded against the accumulator and arc count
// once the queue has room for two results; its results (up to two for a
// first octet, at most one otherwise) go into a four-entry result queue.
// An octet can be taken every cycle as long as the queue has room for two
// results, so the sustained rate is one octet per cycle, bounded by the
// output port at one result per cycle; first octets, with two results each,
// are slower. Every element ends in a result with tlast set and a status.
module ber_oid_arc_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [boad_pkg::IN_TDATA_W-1:0]     s_tdata,  // tag, data_byte
  input  logic [boad_pkg::IN_TUSER_W-1:0]     s_tuser,  // is_first, is_empty
  input  logic                                s_tlast,  // is_last
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [boad_pkg::OUT_TDATA_W-1:0]    m_tdata,  // arc, status, arc_count
  output logic                                m_tuser,  // arc_valid
  output logic                                m_tlast,  // done_res
  input  logic                                cfg_wr_en,
  input  logic [boad_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [boad_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
  import boad_pkg::*;

  boad_cfg_t  cfg;
  boad_item_t in_q;
  logic       in_q_valid;
  logic       advance;
  logic       room2;
  logic       q_not_empty;
  boad_res_t  res0, res1, head;
  logic [1:0] n_res;

  assign advance  = in_q_valid & room2;
  assign s_tready = !in_q_valid | room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_arcs <= ARC_LIMIT;
      cfg.oid_tag  <= OID_TAG_RESET;
    end else if (cfg_wr_en) begin
      case (boad_reg_t'(cfg_index))
        REG_MAX_ARCS: cfg.max_arcs <= cfg_wr_data;
        REG_OID_TAG:  cfg.oid_tag  <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_q.tag       <= s_tdata[7:0];
      in_q.data_byte <= s_tdata[15:8];
      in_q.is_first  <= s_tuser[0];
      in_q.is_empty  <= s_tuser[1];
      in_q.is_last   <= s_tlast;
    end
  end

  boad_step u_step (
    .clk   (clk),
    .rst   (rst),
    .en    (advance),
    .item  (in_q),
    .cfg   (cfg),
    .res0  (res0),
    .res1  (res1),
    .n_res (n_res)
  );

  boad_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .n_push    (n_res),
    .push0     (res0),
    .push1     (res1),
    .pop       (m_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .room2     (room2)
  );

  assign m_tvalid = q_not_empty;
  assign m_tdata  = {5'b0, head.arc_count, head.status, head.arc};
  assign m_tuser  = head.arc_valid;
  assign m_tlast  = head.done_res;

endmodule

// File: rtl/boad_checker.sv
// Port-level checks for the decoder, bound to the top level.
`include "ber_oid_arc_decoder_assert.svh"

module boad_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [boad_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input logic                                m_tuser,
  input logic                                m_tlast
);
  import boad_pkg::*;

  logic [2:0] st;
  logic [7:0] cnt;

  assign st  = m_tdata[34:32];
  assign cnt = m_tdata[42:35];

  // stalled result stays offered
  `BOAD_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

  // a result without an arc is always an error that closes the element
  `BOAD_ASSERT(a_err_final, m_tvalid && !m_tuser |-> m_tlast && st != ST_OK, "bad error result")

  // intermediate results carry no status and no count
  `BOAD_ASSERT(a_mid_clean, m_tvalid && !m_tlast |-> st == ST_OK && cnt == 8'd0, "bad mid result")

  // a closing arc reports at least the two arcs of the first octet
  `BOAD_ASSERT(a_done_cnt, m_tvalid && m_tuser && m_tlast |-> cnt >= 8'd2, "bad arc count")

  // out of reset the queue is empty and input is open
  `BOAD_ASSERT_ALWAYS(a_reset, rst |=> !m_tvalid && s_tready, "reset state wrong")

endmodule

bind ber_oid_arc_decoder boad_checker u_boad_checker (.*);
